>>> sv/apr_pkg.sv
// Shared types and constants for the angle PD regulator.
`default_nettype none

package apr_pkg;

	// Angles are in 1/64 degree.
	localparam int unsigned HALF_TURN = 11520;
	localparam int unsigned FULL_TURN = 23040;

	// Drive limit and the product scale (Q8.8 gain times 1/64 degree is 1/16384).
	localparam int unsigned DRIVE_MAX   = 100;
	localparam int unsigned SCALE_SHIFT = 14;

	// Register map, word index on the configuration port.
	localparam int unsigned ADDR_W = 4;
	localparam logic [1:0] REG_ENABLE   = 2'd0;
	localparam logic [1:0] REG_SETPOINT = 2'd1;
	localparam logic [1:0] REG_GAIN_P   = 2'd2;
	localparam logic [1:0] REG_GAIN_D   = 2'd3;

	localparam logic [15:0] GAIN_P_RST = 16'd205;
	localparam logic [15:0] GAIN_D_RST = 16'd128;

	typedef struct packed {
		logic               enable;
		logic signed [14:0] setpoint;
		logic [15:0]        gain_p;
		logic [15:0]        gain_d;
	} apr_cfg_t;

	typedef struct packed {
		logic               start;
		logic signed [63:0] num;
		logic [31:0]        dt;
	} apr_div_req_t;

	typedef struct packed {
		logic              done;
		logic signed [7:0] drive;
	} apr_div_rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ERR,
		S_MUL1,
		S_MUL2,
		S_MUL3,
		S_SUM,
		S_DIV,
		S_WAIT,
		S_FIN
	} apr_state_t;

endpackage

`default_nettype wire

>>> sv/apr_ifs.sv
// Handshake channel interfaces for samples and drive words.
`default_nettype none

interface apr_sample_if;
	logic               valid;
	logic               ready;
	logic signed [14:0] angle;
	logic [31:0]        now_ms;

	modport source (output valid, output angle, output now_ms, input ready);
	modport sink   (input valid, input angle, input now_ms, output ready);
endinterface

interface apr_drive_if;
	logic              valid;
	logic              ready;
	logic signed [7:0] drive_pos;
	logic signed [7:0] drive_neg;

	modport source (output valid, output drive_pos, output drive_neg, input ready);
	modport sink   (input valid, input drive_pos, input drive_neg, output ready);
endinterface

`default_nettype wire

>>> sv/apr_cfg.sv
// APB-style register file holding enable, setpoint and the two gains.
`default_nettype none

module apr_cfg (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [apr_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [31:0]                  pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	output apr_pkg::apr_cfg_t                 cfg
);

	logic               enable_q;
	logic signed [14:0] setpoint_q;
	logic [15:0]        gain_p_q;
	logic [15:0]        gain_d_q;
	logic               wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q   <= 1'b0;
			setpoint_q <= '0;
			gain_p_q   <= apr_pkg::GAIN_P_RST;
			gain_d_q   <= apr_pkg::GAIN_D_RST;
		end else if (wr_en) begin
			case (paddr[3:2])
				apr_pkg::REG_ENABLE:   enable_q   <= pwdata[0];
				apr_pkg::REG_SETPOINT: setpoint_q <= $signed(pwdata[14:0]);
				apr_pkg::REG_GAIN_P:   gain_p_q   <= pwdata[15:0];
				apr_pkg::REG_GAIN_D:   gain_d_q   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			apr_pkg::REG_ENABLE:   prdata = {31'b0, enable_q};
			apr_pkg::REG_SETPOINT: prdata = 32'(setpoint_q);
			apr_pkg::REG_GAIN_P:   prdata = {16'b0, gain_p_q};
			apr_pkg::REG_GAIN_D:   prdata = {16'b0, gain_d_q};
			default:               prdata = '0;
		endcase
	end

	assign cfg.enable   = enable_q;
	assign cfg.setpoint = setpoint_q;
	assign cfg.gain_p   = gain_p_q;
	assign cfg.gain_d   = gain_d_q;

endmodule

`default_nettype wire

>>> sv/apr_div.sv
// Restoring divider that turns the drive numerator into a clamped signed drive.
`default_nettype none

module apr_div (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire apr_pkg::apr_div_req_t req,
	output apr_pkg::apr_div_rsp_t      rsp
);

	logic        busy_q;
	logic        done_q;
	logic [2:0]  k_q;
	logic [31:0] dt_q;
	logic [62:0] rem_q;
	logic [6:0]  quo_q;
	logic        sat_q;
	logic        neg_q;

	logic [63:0] num_mag;
	logic [52:0] dsh;
	logic [62:0] dsh_ext;
	logic        ge;
	logic [7:0]  mag;

	assign num_mag = req.num[63] ? 64'(-req.num) : 64'(req.num);

	// Divisor is dt scaled by 2^14, shifted by the current quotient bit.
	assign dsh     = {7'b0, dt_q, 14'b0} << k_q;
	assign dsh_ext = {10'b0, dsh};
	assign ge      = rem_q >= dsh_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			k_q    <= '0;
		end else begin
			done_q <= busy_q && (k_q == 3'd0);
			if (req.start) begin
				busy_q <= 1'b1;
				k_q    <= 3'd7;
			end else if (busy_q) begin
				if (k_q == 3'd0) begin
					busy_q <= 1'b0;
				end else begin
					k_q <= k_q - 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dt_q  <= req.dt;
			rem_q <= num_mag[62:0];
			neg_q <= req.num[63];
			quo_q <= '0;
			sat_q <= 1'b0;
		end else if (busy_q) begin
			if (k_q == 3'd7) begin
				// A quotient of 128 or more is past the drive limit.
				sat_q <= ge;
			end else begin
				quo_q <= {quo_q[5:0], ge};
				if (ge) begin
					rem_q <= rem_q - dsh_ext;
				end
			end
		end
	end

	always_comb begin
		if (sat_q || ({1'b0, quo_q} > 8'(apr_pkg::DRIVE_MAX))) begin
			mag = 8'(apr_pkg::DRIVE_MAX);
		end else begin
			mag = {1'b0, quo_q};
		end
	end

	assign rsp.done  = done_q;
	assign rsp.drive = neg_q ? $signed(-mag) : $signed(mag);

endmodule

`default_nettype wire

>>> sv/angle_pd_regulator.sv
// Top level of the angle PD regulator: sequencer, shared multiplier and output register.
`default_nettype none

// Channel   Dir  Payload                           Handshake
// sample    in   angle (s15), now_ms (u32)         valid/ready
// drive     out  drive_pos (s8), drive_neg (s8)    valid/ready
// apb       in   enable, setpoint, gain_p, gain_d  psel/penable, pready tied high
//
// A sample word passes from acceptance to a result in the output register in
// order: the error and elapsed time are formed, three passes through the
// shared 33x33 multiplier and one add follow, and the divider runs its eight
// compare/subtract steps. Reset clears the sequencer, the history and
// the output valid. A stalled output holds the finished word, and the block takes
// the next sample as soon as that word has moved into the output register.
module angle_pd_regulator (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	apr_sample_if.sink                      sample,
	apr_drive_if.source                     drive,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [apr_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);

	apr_pkg::apr_cfg_t     cfg;
	apr_pkg::apr_div_req_t div_req;
	apr_pkg::apr_div_rsp_t div_rsp;
	apr_pkg::apr_state_t   state_q;
	apr_pkg::apr_state_t   state_d;

	// Captured sample and the regulator's history.
	logic signed [14:0] angle_q;
	logic [31:0]        now_q;
	logic signed [14:0] last_err_q;
	logic [31:0]        last_time_q;
	logic               primed_q;

	// Working registers.
	logic signed [14:0] err_q;
	logic [31:0]        dt_q;
	logic signed [63:0] prod_q;
	logic signed [63:0] acc_q;

	// Output register.
	logic               out_valid_q;
	logic signed [7:0]  out_pos_q;
	logic signed [7:0]  out_neg_q;

	logic               accept;
	logic               load;
	logic signed [16:0] diff;
	logic signed [16:0] wrapped;
	logic [31:0]        elapsed;
	logic signed [16:0] derr;
	logic signed [32:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [65:0] prod;

	apr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	apr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign sample.ready = (state_q == apr_pkg::S_IDLE);
	assign accept       = sample.valid & sample.ready;

	// Error is wrapped once into plus or minus half a turn.
	assign diff = 17'(angle_q) - 17'(cfg.setpoint);
	always_comb begin
		if (diff > 17'sd11520) begin
			wrapped = diff - 17'(apr_pkg::FULL_TURN);
		end else if (diff < -17'sd11520) begin
			wrapped = diff + 17'(apr_pkg::FULL_TURN);
		end else begin
			wrapped = diff;
		end
	end

	assign elapsed = now_q - last_time_q;
	assign derr    = 17'(err_q) - 17'(last_err_q);

	// Shared multiplier: gain_p * err, then times dt, then gain_d * error change.
	// The first sample has no derivative, so gain_d is replaced by zero.
	always_comb begin
		case (state_q)
			apr_pkg::S_MUL1: begin
				mul_a = $signed({17'b0, cfg.gain_p});
				mul_b = 33'(err_q);
			end
			apr_pkg::S_MUL2: begin
				mul_a = $signed(prod_q[32:0]);
				mul_b = $signed({1'b0, dt_q});
			end
			apr_pkg::S_MUL3: begin
				mul_a = primed_q ? $signed({17'b0, cfg.gain_d}) : '0;
				mul_b = 33'(derr);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	assign div_req.start = (state_q == apr_pkg::S_DIV);
	assign div_req.num   = acc_q;
	assign div_req.dt    = dt_q;

	always_comb begin
		state_d = state_q;
		load    = 1'b0;
		case (state_q)
			apr_pkg::S_IDLE: begin
				// A sample taken while disabled is dropped without leaving idle or touching the history.
				if (accept && cfg.enable) begin
					state_d = apr_pkg::S_ERR;
				end
			end
			apr_pkg::S_ERR:  state_d = apr_pkg::S_MUL1;
			apr_pkg::S_MUL1: state_d = apr_pkg::S_MUL2;
			apr_pkg::S_MUL2: state_d = apr_pkg::S_MUL3;
			apr_pkg::S_MUL3: state_d = apr_pkg::S_SUM;
			apr_pkg::S_SUM:  state_d = apr_pkg::S_DIV;
			apr_pkg::S_DIV:  state_d = apr_pkg::S_WAIT;
			apr_pkg::S_WAIT: begin
				if (div_rsp.done) begin
					state_d = apr_pkg::S_FIN;
				end
			end
			apr_pkg::S_FIN: begin
				if (!out_valid_q || drive.ready) begin
					load    = 1'b1;
					state_d = apr_pkg::S_IDLE;
				end
			end
			default: state_d = apr_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= apr_pkg::S_IDLE;
			primed_q    <= 1'b0;
			last_err_q  <= '0;
			last_time_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				primed_q    <= 1'b1;
				last_err_q  <= err_q;
				last_time_q <= now_q;
				out_valid_q <= 1'b1;
			end else if (drive.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			angle_q <= sample.angle;
			now_q   <= sample.now_ms;
		end
		if (state_q == apr_pkg::S_ERR) begin
			err_q <= 15'(wrapped);
			// Zero elapsed time counts as 1 ms; the first sample uses 1 ms too.
			dt_q  <= (!primed_q || (elapsed == 32'd0)) ? 32'd1 : elapsed;
		end
		if (state_q inside {apr_pkg::S_MUL1, apr_pkg::S_MUL2, apr_pkg::S_MUL3}) begin
			prod_q <= prod[63:0];
		end
		if (state_q == apr_pkg::S_MUL3) begin
			acc_q <= prod_q;
		end else if (state_q == apr_pkg::S_SUM) begin
			acc_q <= acc_q + prod_q;
		end
		if (load) begin
			out_pos_q <= div_rsp.drive;
			out_neg_q <= -div_rsp.drive;
		end
	end

	assign drive.valid     = out_valid_q;
	assign drive.drive_pos = out_pos_q;
	assign drive.drive_neg = out_neg_q;

	// A word enters the output register only from the final sequencer step.
	a_load_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == apr_pkg::S_FIN))
		else $error("output word loaded outside the final step");

	// A disabled sample leaves the sequencer idle.
	a_disabled_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !cfg.enable) |=> (state_q == apr_pkg::S_IDLE))
		else $error("disabled sample started the sequencer");

	// Once a sample has been processed the history stays primed.
	a_primed_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(primed_q))
		else $error("history lost its primed mark");

	// The drive stays inside the limit.
	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		drive.valid |-> (drive.drive_pos <= 8'sd100 && drive.drive_pos >= -8'sd100))
		else $error("drive outside limit");

endmodule

`default_nettype wire
